// File: rtl/lirs_pkg.sv
// Shared constants and codes for the linear interpolation time resampler.
// No dependencies; used by the channel interfaces and the core.
package lirs_pkg;

   localparam int TIME_BITS     = 32;
   localparam int STEP_BITS     = 16;
   localparam int FRAC_BITS     = 16;
   localparam int NUM_CH        = 5;
   localparam int CH_BITS       = 3;
   localparam int STEP_CNT_BITS = 6;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [STEP_BITS-1:0] TIME_STEP_RESET = 16'd3600;

   typedef enum logic [0:0] {
      CSR_TIME_STEP = 1'b0
   } csr_index_type;

endpackage

// File: rtl/lirs_req_if.sv
// Request channel of the resampler: one wind record per handshake.
// Depends on lirs_pkg for the time stamp width.
interface lirs_req_if #(
   parameter int VALUE_BITS = 16
);
   logic                               valid;
   logic                               ready;
   logic [lirs_pkg::TIME_BITS-1:0]     sample_time;
   logic signed [VALUE_BITS-1:0]       wind_u;
   logic signed [VALUE_BITS-1:0]       wind_v;
   logic signed [VALUE_BITS-1:0]       sigma_u;
   logic signed [VALUE_BITS-1:0]       sigma_v;
   logic signed [VALUE_BITS-1:0]       cov_uv;
   logic                               missing;

   modport source (
      output valid, sample_time, wind_u, wind_v, sigma_u, sigma_v, cov_uv, missing,
      input  ready
   );
   modport sink (
      input  valid, sample_time, wind_u, wind_v, sigma_u, sigma_v, cov_uv, missing,
      output ready
   );
endinterface

// File: rtl/lirs_rsp_if.sv
// Response channel of the resampler: one grid point per handshake.
// Depends on lirs_pkg for the time stamp width.
interface lirs_rsp_if #(
   parameter int VALUE_BITS = 16
);
   logic                               valid;
   logic                               ready;
   logic [lirs_pkg::TIME_BITS-1:0]     grid_time;
   logic signed [VALUE_BITS-1:0]       out_u;
   logic signed [VALUE_BITS-1:0]       out_v;
   logic signed [VALUE_BITS-1:0]       out_sigma_u;
   logic signed [VALUE_BITS-1:0]       out_sigma_v;
   logic signed [VALUE_BITS-1:0]       out_cov;
   logic                               exact_hit;
   logic                               last_of_run;
   logic                               points_skipped;

   modport source (
      output valid, grid_time, out_u, out_v, out_sigma_u, out_sigma_v, out_cov,
             exact_hit, last_of_run, points_skipped,
      input  ready
   );
   modport sink (
      input  valid, grid_time, out_u, out_v, out_sigma_u, out_sigma_v, out_cov,
             exact_hit, last_of_run, points_skipped,
      output ready
   );
endinterface

// File: rtl/linear_interp_time_resampler_core.sv
// Top level of the linear interpolation time resampler.
// Depends on lirs_pkg, lirs_req_if and lirs_rsp_if.
//
// Wind records arrive in ascending time order and are resampled onto a grid that starts
// at the first valid record and is spaced by the time_step register (zero acts as one
// second). The block works on one request at a time and holds req.ready low meanwhile.
// A missing or out-of-order record, or one whose gap holds no grid point, is dealt with
// in S_IDLE alone. The first valid record is accepted in S_IDLE and its copy is handed
// to the output register in S_PUSH. Any other record goes through the shared restoring
// divider in S_CNT, then S_CNT_END, to count the grid points in its gap, then for each
// emitted point takes 16 divider steps for the interpolation fraction, a multiply and
// an accumulate per channel on the single multiplier, and a push to hand the point to
// the output register. An exact hit skips the fraction and the multiplies. A point waits
// while the output register still holds an unaccepted one. The output register lets a
// new request be taken while the last point still waits. At most MAX_RUN points are
// given per request; the rest of that gap is skipped and flagged.
module linear_interp_time_resampler_core #(
   parameter int MAX_RUN    = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   lirs_req_if.sink                                req,
   lirs_rsp_if.source                              rsp,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [lirs_pkg::CSR_ADDR_BITS-1:0]      paddr,
   input  logic [lirs_pkg::CSR_DATA_BITS-1:0]      pwdata,
   output logic [lirs_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                    pready
);

   localparam int TB        = lirs_pkg::TIME_BITS;
   localparam int SB        = lirs_pkg::STEP_BITS;
   localparam int FB        = lirs_pkg::FRAC_BITS;
   localparam int NCH       = lirs_pkg::NUM_CH;
   localparam int CB        = lirs_pkg::CH_BITS;
   localparam int SCB       = lirs_pkg::STEP_CNT_BITS;
   localparam int RUN_BITS  = $clog2(MAX_RUN + 1);
   localparam int PROD_BITS = VALUE_BITS + FB + 2;
   localparam int CSR_ADDR_BITS_IDX = 2;
   localparam int CSR_WORD          = lirs_pkg::CSR_DATA_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_CNT, S_CNT_END, S_POINT, S_FRAC, S_MUL, S_ACC, S_PUSH
   } state_type;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   state_type                 state_ff, state_in;
   logic [SCB-1:0]            step_cnt_ff, step_cnt_in;
   logic [CB-1:0]             ch_ff, ch_in;
   logic [RUN_BITS-1:0]       k_ff, k_in;
   logic [RUN_BITS-1:0]       emit_ff, emit_in;
   logic                      skip_ff, skip_in;
   logic                      have_prev_ff, have_prev_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]             time_step_ff, time_step_in;

   logic [TB-1:0]             prev_time_ff, prev_time_in;
   value_type                 prev_vals_ff [NCH];
   value_type                 prev_vals_in [NCH];
   logic [TB:0]               next_grid_ff, next_grid_in;
   logic [TB:0]               next_new_ff, next_new_in;
   logic [TB:0]               gk_ff, gk_in;
   logic [TB-1:0]             t_ff, t_in;
   value_type                 v_ff [NCH];
   value_type                 v_in [NCH];
   logic [TB-1:0]             rem_ff, rem_in;
   logic [TB-1:0]             quo_ff, quo_in;
   logic [TB-1:0]             div_ff, div_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;

   logic [TB-1:0]             res_time_ff, res_time_in;
   value_type                 res_vals_ff [NCH];
   value_type                 res_vals_in [NCH];
   logic                      res_exact_ff, res_exact_in;
   logic                      res_last_ff, res_last_in;
   logic                      res_skip_ff, res_skip_in;

   logic [TB-1:0]             out_time_ff, out_time_in;
   value_type                 out_vals_ff [NCH];
   value_type                 out_vals_in [NCH];
   logic                      out_exact_ff, out_exact_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_skip_ff, out_skip_in;

   logic [SB-1:0]             step_eff;
   logic [TB:0]               div_shl;
   logic                      div_ge;
   logic [TB:0]               div_diff;
   logic signed [FB:0]        mul_a;
   logic signed [VALUE_BITS:0] mul_b;
   logic signed [PROD_BITS-1:0] prod_round;
   value_type                 req_vals [NCH];
   logic                      csr_write;

   assign step_eff = (time_step_ff == '0) ? SB'(1) : time_step_ff;

   assign div_shl  = {rem_ff, quo_ff[TB-1]};
   assign div_ge   = div_shl >= {1'b0, div_ff};
   assign div_diff = div_shl - {1'b0, div_ff};

   assign mul_a = $signed({1'b0, quo_ff[FB-1:0]});
   assign mul_b = $signed({v_ff[ch_ff][VALUE_BITS-1], v_ff[ch_ff]})
                - $signed({prev_vals_ff[ch_ff][VALUE_BITS-1], prev_vals_ff[ch_ff]});
   assign prod_round = prod_ff + PROD_BITS'(1 << (FB - 1));

   assign req_vals[0] = req.wind_u;
   assign req_vals[1] = req.wind_v;
   assign req_vals[2] = req.sigma_u;
   assign req_vals[3] = req.sigma_v;
   assign req_vals[4] = req.cov_uv;

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[CSR_ADDR_BITS_IDX] == lirs_pkg::CSR_TIME_STEP)
                    ? CSR_WORD'(time_step_ff) : '0;

   assign req.ready          = (state_ff == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.grid_time      = out_time_ff;
   assign rsp.out_u          = out_vals_ff[0];
   assign rsp.out_v          = out_vals_ff[1];
   assign rsp.out_sigma_u    = out_vals_ff[2];
   assign rsp.out_sigma_v    = out_vals_ff[3];
   assign rsp.out_cov        = out_vals_ff[4];
   assign rsp.exact_hit      = out_exact_ff;
   assign rsp.last_of_run    = out_last_ff;
   assign rsp.points_skipped = out_skip_ff;

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      ch_in        = ch_ff;
      k_in         = k_ff;
      emit_in      = emit_ff;
      skip_in      = skip_ff;
      have_prev_in = have_prev_ff;
      rsp_valid_in = rsp_valid_ff;
      time_step_in = time_step_ff;
      prev_time_in = prev_time_ff;
      prev_vals_in = prev_vals_ff;
      next_grid_in = next_grid_ff;
      next_new_in  = next_new_ff;
      gk_in        = gk_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      prod_in      = prod_ff;
      res_time_in  = res_time_ff;
      res_vals_in  = res_vals_ff;
      res_exact_in = res_exact_ff;
      res_last_in  = res_last_ff;
      res_skip_in  = res_skip_ff;
      out_time_in  = out_time_ff;
      out_vals_in  = out_vals_ff;
      out_exact_in = out_exact_ff;
      out_last_in  = out_last_ff;
      out_skip_in  = out_skip_ff;

      if (csr_write && paddr[CSR_ADDR_BITS_IDX] == lirs_pkg::CSR_TIME_STEP) begin
         time_step_in = pwdata[SB-1:0];
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               t_in = req.sample_time;
               v_in = req_vals;
               if (req.missing) begin
                  state_in = S_IDLE;
               end else if (!have_prev_ff) begin
                  have_prev_in = 1'b1;
                  next_new_in  = {1'b0, req.sample_time} + (TB+1)'(step_eff);
                  res_time_in  = req.sample_time;
                  res_vals_in  = req_vals;
                  res_exact_in = 1'b1;
                  res_last_in  = 1'b1;
                  res_skip_in  = 1'b0;
                  state_in     = S_PUSH;
               end else if (req.sample_time <= prev_time_ff) begin
                  state_in = S_IDLE;
               end else if (next_grid_ff > {1'b0, req.sample_time}) begin
                  prev_time_in = req.sample_time;
                  prev_vals_in = req_vals;
               end else begin
                  rem_in      = '0;
                  quo_in      = req.sample_time - next_grid_ff[TB-1:0];
                  div_in      = TB'(step_eff);
                  step_cnt_in = SCB'(TB);
                  state_in    = S_CNT;
               end
            end
         end
         S_CNT: begin
            rem_in      = div_ge ? div_diff[TB-1:0] : div_shl[TB-1:0];
            quo_in      = {quo_ff[TB-2:0], div_ge};
            step_cnt_in = step_cnt_ff - SCB'(1);
            if (step_cnt_ff == SCB'(1)) begin
               state_in = S_CNT_END;
            end
         end
         S_CNT_END: begin
            skip_in     = quo_ff >= TB'(MAX_RUN);
            emit_in     = (quo_ff >= TB'(MAX_RUN)) ? RUN_BITS'(MAX_RUN)
                                                   : RUN_BITS'(quo_ff + TB'(1));
            next_new_in = {1'b0, t_ff} - (TB+1)'(rem_ff) + (TB+1)'(step_eff);
            gk_in       = next_grid_ff;
            k_in        = '0;
            state_in    = S_POINT;
         end
         S_POINT: begin
            res_time_in = gk_ff[TB-1:0];
            res_last_in = (k_ff + RUN_BITS'(1)) == emit_ff;
            res_skip_in = skip_ff;
            if (gk_ff == {1'b0, t_ff}) begin
               res_vals_in  = v_ff;
               res_exact_in = 1'b1;
               state_in     = S_PUSH;
            end else begin
               res_exact_in = 1'b0;
               rem_in       = gk_ff[TB-1:0] - prev_time_ff;
               quo_in       = '0;
               div_in       = t_ff - prev_time_ff;
               step_cnt_in  = SCB'(FB);
               state_in     = S_FRAC;
            end
         end
         S_FRAC: begin
            rem_in      = div_ge ? div_diff[TB-1:0] : div_shl[TB-1:0];
            quo_in      = {quo_ff[TB-2:0], div_ge};
            step_cnt_in = step_cnt_ff - SCB'(1);
            if (step_cnt_ff == SCB'(1)) begin
               ch_in    = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
            state_in = S_ACC;
         end
         S_ACC: begin
            res_vals_in[ch_ff] = prev_vals_ff[ch_ff] + prod_round[FB +: VALUE_BITS];
            if (ch_ff == CB'(NCH - 1)) begin
               state_in = S_PUSH;
            end else begin
               ch_in    = ch_ff + CB'(1);
               state_in = S_MUL;
            end
         end
         S_PUSH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_time_in  = res_time_ff;
               out_vals_in  = res_vals_ff;
               out_exact_in = res_exact_ff;
               out_last_in  = res_last_ff;
               out_skip_in  = res_skip_ff;
               if (res_last_ff) begin
                  prev_time_in = t_ff;
                  prev_vals_in = v_ff;
                  next_grid_in = next_new_ff;
                  state_in     = S_IDLE;
               end else begin
                  gk_in    = gk_ff + (TB+1)'(step_eff);
                  k_in     = k_ff + RUN_BITS'(1);
                  state_in = S_POINT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_cnt_ff  <= '0;
         ch_ff        <= '0;
         k_ff         <= '0;
         emit_ff      <= '0;
         skip_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_step_ff <= lirs_pkg::TIME_STEP_RESET;
         prev_time_ff <= '0;
         next_grid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         ch_ff        <= ch_in;
         k_ff         <= k_in;
         emit_ff      <= emit_in;
         skip_ff      <= skip_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         time_step_ff <= time_step_in;
         prev_time_ff <= prev_time_in;
         next_grid_ff <= next_grid_in;
      end
      prev_vals_ff <= prev_vals_in;
      next_new_ff  <= next_new_in;
      gk_ff        <= gk_in;
      t_ff         <= t_in;
      v_ff         <= v_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_ff       <= div_in;
      prod_ff      <= prod_in;
      res_time_ff  <= res_time_in;
      res_vals_ff  <= res_vals_in;
      res_exact_ff <= res_exact_in;
      res_last_ff  <= res_last_in;
      res_skip_ff  <= res_skip_in;
      out_time_ff  <= out_time_in;
      out_vals_ff  <= out_vals_in;
      out_exact_ff <= out_exact_in;
      out_last_ff  <= out_last_in;
      out_skip_ff  <= out_skip_in;
   end

   // The grid never falls behind the last accepted record.
   a_grid_ahead: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && have_prev_ff) |-> (next_grid_ff > {1'b0, prev_time_ff}))
      else $error("next grid point is not past the previous record");

   // A point is only produced while the run count allows it.
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POINT) |-> (k_ff < emit_ff && emit_ff <= RUN_BITS'(MAX_RUN)))
      else $error("grid point index beyond the run length");

   // The fraction divide leaves a remainder below the record span.
   a_frac_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FRAC && step_cnt_ff == SCB'(1)) |=> (rem_ff < div_ff))
      else $error("fraction remainder not below span");

   // An exact copy can only be the final point of its run.
   a_exact_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && res_exact_ff) |-> res_last_ff)
      else $error("exact hit before the end of a run");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_time_resampler_core: it drives wind records,
// predicts every grid point in its own resampler and checks them in order.
// Depends on lirs_pkg, lirs_req_if, lirs_rsp_if and the core under rtl.
module tb_top;

   localparam int TIME_BITS     = lirs_pkg::TIME_BITS;
   localparam int STEP_BITS     = lirs_pkg::STEP_BITS;
   localparam int FRAC_BITS     = lirs_pkg::FRAC_BITS;
   localparam int NUM_CH        = lirs_pkg::NUM_CH;
   localparam int CSR_ADDR_BITS = lirs_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = lirs_pkg::CSR_DATA_BITS;
   localparam int VALUE_BITS = 16;
   localparam int MAX_RUN = 64;
   localparam int QUIET_CYCLES = 64;
   localparam int SPARE_CSR_INDEX = 1;

   typedef struct packed {
      logic [TIME_BITS-1:0] sample_time;
      logic [15:0]          wind_u;
      logic [15:0]          wind_v;
      logic [15:0]          sigma_u;
      logic [15:0]          sigma_v;
      logic [15:0]          cov_uv;
      logic                 missing;
   } wind_record_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] grid_time;
      logic [15:0]          out_u;
      logic [15:0]          out_v;
      logic [15:0]          out_sigma_u;
      logic [15:0]          out_sigma_v;
      logic [15:0]          out_cov;
      logic                 exact_hit;
      logic                 last_of_run;
      logic                 points_skipped;
   } grid_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   lirs_req_if #(.VALUE_BITS(VALUE_BITS)) req_if ();
   lirs_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_if ();

   linear_interp_time_resampler_core #(
      .MAX_RUN    (MAX_RUN),
      .VALUE_BITS (VALUE_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   wind_record_type pending_records[$];
   grid_point_type  expected_points[$];
   wind_record_type offered_record;
   int           error_count = 0;
   logic         calm_phase = 1'b0;
   int           send_hold;
   int           rsp_hold;

   // Resampler state as seen by the predictor.
   logic [STEP_BITS-1:0] step_setting = lirs_pkg::TIME_STEP_RESET;
   logic                 have_held = 1'b0;
   longint unsigned      held_time = 0;
   longint               held_values [NUM_CH] = '{default: 0};
   longint unsigned      grid_cursor = 0;

   // Mirror of the time line kept by the stimulus, used to aim at grid points.
   logic            gen_started = 1'b0;
   longint unsigned gen_last_time = 0;
   longint unsigned gen_grid = 0;

   function automatic void push_point(input longint unsigned gt, input longint vals [NUM_CH],
                                      input logic exact, input logic last, input logic skip);
      grid_point_type pt;
      pt.grid_time      = gt[TIME_BITS-1:0];
      pt.out_u          = 16'(vals[0]);
      pt.out_v          = 16'(vals[1]);
      pt.out_sigma_u    = 16'(vals[2]);
      pt.out_sigma_v    = 16'(vals[3]);
      pt.out_cov        = 16'(vals[4]);
      pt.exact_hit      = exact;
      pt.last_of_run    = last;
      pt.points_skipped = skip;
      expected_points = {expected_points, pt};
   endfunction

   function automatic void resample_record(input wind_record_type rec);
      longint unsigned t, st, g, gk, count, emit, span, frac;
      longint cur_vals [NUM_CH];
      longint mix_vals [NUM_CH];
      longint q;
      logic skip;
      if (rec.missing) return;
      t = rec.sample_time;
      st = (step_setting == '0) ? 1 : step_setting;
      cur_vals[0] = $signed(rec.wind_u);
      cur_vals[1] = $signed(rec.wind_v);
      cur_vals[2] = $signed(rec.sigma_u);
      cur_vals[3] = $signed(rec.sigma_v);
      cur_vals[4] = $signed(rec.cov_uv);
      if (!have_held) begin
         have_held = 1'b1;
         held_time = t;
         held_values = cur_vals;
         grid_cursor = t + st;
         push_point(t, cur_vals, 1'b1, 1'b1, 1'b0);
         return;
      end
      if (t <= held_time) return;
      g = grid_cursor;
      count = (g > t) ? 0 : (t - g) / st + 1;
      emit = (count > MAX_RUN) ? MAX_RUN : count;
      skip = (count > emit);
      span = t - held_time;
      for (longint unsigned k = 0; k < emit; k++) begin
         gk = g + k * st;
         if (gk == t) begin
            push_point(gk, cur_vals, 1'b1, (k + 1 == emit), skip);
         end else begin
            frac = ((gk - held_time) << FRAC_BITS) / span;
            for (int c = 0; c < NUM_CH; c++) begin
               q = longint'(frac) * (cur_vals[c] - held_values[c])
                   + (longint'(1) <<< (FRAC_BITS - 1));
               mix_vals[c] = held_values[c] + (q >>> FRAC_BITS);
            end
            push_point(gk, mix_vals, 1'b0, (k + 1 == emit), skip);
         end
      end
      if (count > 0) grid_cursor = (g + count * st) & 64'h1_FFFF_FFFF;
      held_time = t;
      held_values = cur_vals;
   endfunction

   function automatic void compare_field(input string field, input longint unsigned want,
                                         input longint unsigned got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_hold <= 0;
      end else begin
         if (req_if.valid && req_if.ready) resample_record(offered_record);
         if (!req_if.valid || req_if.ready) begin
            if (send_hold > 0) begin
               send_hold <= send_hold - 1;
               req_if.valid <= 1'b0;
            end else if (pending_records.size() > 0) begin
               offered_record = pending_records.pop_front();
               req_if.sample_time <= offered_record.sample_time;
               req_if.wind_u <= offered_record.wind_u;
               req_if.wind_v <= offered_record.wind_v;
               req_if.sigma_u <= offered_record.sigma_u;
               req_if.sigma_v <= offered_record.sigma_v;
               req_if.cov_uv <= offered_record.cov_uv;
               req_if.missing <= offered_record.missing;
               req_if.valid <= 1'b1;
               send_hold <= calm_phase ? 0 : $urandom_range(0, 7);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Grid point monitor.
   always @(posedge clock) begin
      grid_point_type got;
      grid_point_type want;
      int hold;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         got.grid_time      = rsp_if.grid_time;
         got.out_u          = rsp_if.out_u;
         got.out_v          = rsp_if.out_v;
         got.out_sigma_u    = rsp_if.out_sigma_u;
         got.out_sigma_v    = rsp_if.out_sigma_v;
         got.out_cov        = rsp_if.out_cov;
         got.exact_hit      = rsp_if.exact_hit;
         got.last_of_run    = rsp_if.last_of_run;
         got.points_skipped = rsp_if.points_skipped;
         if (expected_points.size() == 0) begin
            $display("%0t unexpected grid point: expected none, actual time %0d",
                     $time, got.grid_time);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            compare_field("grid_time", want.grid_time, got.grid_time);
            compare_field("out_u", want.out_u, got.out_u);
            compare_field("out_v", want.out_v, got.out_v);
            compare_field("out_sigma_u", want.out_sigma_u, got.out_sigma_u);
            compare_field("out_sigma_v", want.out_sigma_v, got.out_sigma_v);
            compare_field("out_cov", want.out_cov, got.out_cov);
            compare_field("exact_hit", want.exact_hit, got.exact_hit);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            compare_field("points_skipped", want.points_skipped, got.points_skipped);
         end
         hold = calm_phase ? 0 : $urandom_range(0, 7);
         rsp_if.ready <= (hold == 0);
         rsp_hold <= hold;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_if.ready <= (rsp_hold == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic logic [15:0] rand_value();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return 16'h8000;
      if (pick == 1) return 16'h7FFF;
      if (pick == 2) return 16'h0000;
      return 16'($urandom);
   endfunction

   function automatic void queue_record(input longint unsigned t, input logic miss,
                                        input logic [15:0] u, input logic [15:0] v,
                                        input logic [15:0] su, input logic [15:0] sv,
                                        input logic [15:0] cov);
      wind_record_type rec;
      longint unsigned st;
      st = (step_setting == '0) ? 1 : step_setting;
      rec.sample_time = t[TIME_BITS-1:0];
      rec.wind_u = u;
      rec.wind_v = v;
      rec.sigma_u = su;
      rec.sigma_v = sv;
      rec.cov_uv = cov;
      rec.missing = miss;
      pending_records = {pending_records, rec};
      if (!miss) begin
         if (!gen_started) begin
            gen_started = 1'b1;
            gen_last_time = t;
            gen_grid = t + st;
         end else if (t > gen_last_time) begin
            if (t >= gen_grid) gen_grid += ((t - gen_grid) / st + 1) * st;
            gen_last_time = t;
         end
      end
   endfunction

   function automatic void queue_random(input longint unsigned t, input logic miss);
      queue_record(t, miss, rand_value(), rand_value(), rand_value(), rand_value(),
                   rand_value());
   endfunction

   task automatic random_phase(input int count);
      longint unsigned st;
      longint unsigned t;
      int pick;
      st = (step_setting == '0) ? 1 : step_setting;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            t = gen_last_time + $urandom_range(0, 3 * st);
         else if (pick < 10)
            t = gen_last_time - ((gen_last_time > 50) ? $urandom_range(0, 50) : 0);
         else if (pick < 13)
            t = gen_last_time + st * $urandom_range(65, 80) + $urandom_range(0, st - 1);
         else if (pick < 40)
            t = gen_grid + st * $urandom_range(0, 2);
         else
            t = gen_last_time + $urandom_range(1, 3 * st);
         queue_random(t, pick < 6);
      end
   endtask

   task automatic drain_pipeline();
      do @(negedge clock);
      while (pending_records.size() != 0 || req_if.valid || expected_points.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write_op, input int index,
                             input logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write_op;
      paddr <= CSR_ADDR_BITS'(4 * index);
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_time_step();
      logic [CSR_DATA_BITS-1:0] readback;
      csr_access(1'b0, lirs_pkg::CSR_TIME_STEP, '0, readback);
      if (readback != CSR_DATA_BITS'(step_setting)) begin
         $display("%0t time_step readback mismatch: expected %0h, actual %0h",
                  $time, step_setting, readback);
         error_count++;
      end
   endtask

   task automatic program_time_step(input logic [STEP_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] unused;
      csr_access(1'b1, lirs_pkg::CSR_TIME_STEP, CSR_DATA_BITS'(value), unused);
      step_setting = value;
      check_time_step();
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] unused;
      req_if.valid = 1'b0;
      req_if.sample_time = '0;
      req_if.wind_u = '0;
      req_if.wind_v = '0;
      req_if.sigma_u = '0;
      req_if.sigma_v = '0;
      req_if.cov_uv = '0;
      req_if.missing = 1'b0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      check_time_step();

      // Reset step of one hour: first record, dropped records, empty gaps, full swings.
      queue_random(5, 1'b1);
      queue_record(0, 1'b0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001);
      queue_random(0, 1'b0);
      queue_random(1800, 1'b1);
      queue_record(1800, 1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000);
      queue_random(1799, 1'b0);
      queue_record(10800, 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
      queue_random(12000, 1'b0);
      queue_random(14400, 1'b0);
      queue_random(21700, 1'b0);
      drain_pipeline();

      // One second step: the grid stays where the old step left it; a long gap overflows.
      program_time_step(16'd1);
      queue_random(21710, 1'b0);
      queue_random(25200, 1'b0);
      queue_random(25201, 1'b0);
      queue_random(25301, 1'b0);
      queue_random(25302, 1'b0);
      drain_pipeline();

      // A write outside the register map must leave time_step alone.
      csr_access(1'b1, SPARE_CSR_INDEX, 32'h0000_0005, unused);
      check_time_step();
      program_time_step(16'd0);
      queue_random(25305, 1'b0);
      drain_pipeline();

      program_time_step(16'd1);
      random_phase(50);
      drain_pipeline();
      calm_phase = 1'b1;
      program_time_step(16'd13);
      random_phase(50);
      drain_pipeline();
      calm_phase = 1'b0;
      program_time_step(STEP_BITS'($urandom_range(2, 5000)));
      random_phase(50);
      drain_pipeline();
      program_time_step(16'hFFFF);
      random_phase(50);
      drain_pipeline();
      program_time_step(16'd0);
      random_phase(30);
      drain_pipeline();
      program_time_step(16'd900);
      random_phase(40);
      drain_pipeline();

      // Top of the time range; nothing can follow these records.
      program_time_step(16'hFFFF);
      queue_random(64'hFFFF_0000, 1'b0);
      queue_random(64'hFFFF_FFFF, 1'b0);
      drain_pipeline();

      if (error_count == 0)
         $display("[linear_interp_time_resampler_core] OK");
      else
         $display("[linear_interp_time_resampler_core] ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("[linear_interp_time_resampler_core] ERROR");
      $finish;
   end

endmodule
